/* rtl/msb_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, codes and types for the multi-stack shared buffer.
// No dependencies; imported by msb_ctrl, msb_dp and the top module.
package msb_pkg;

  localparam int NUM_STACKS = 8;
  localparam int NUM_SLOTS  = 64;

  localparam int SID_W   = 3;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int SLOT_W  = $clog2(NUM_SLOTS);
  localparam int LINK_W  = $clog2(NUM_SLOTS + 1);
  localparam int STK_IW  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(NUM_SLOTS);

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic load;    // latch request, launch memory reads
    logic commit;  // update lists, write memories, load result register
  } msb_cmd_t;

  function automatic logic link_is_null(input logic [LINK_W-1:0] lnk);
    return 32'(lnk) >= NUM_SLOTS;
  endfunction

  function automatic logic [LINK_W-1:0] link_norm(input logic [LINK_W-1:0] lnk);
    return link_is_null(lnk) ? LINK_NULL : lnk;
  endfunction

endpackage

/* rtl/msb_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module msb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data until the next read
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/msb_ctrl.sv */
`timescale 1ns / 1ps
// Request sequencer: two-step load/commit flow and the result valid flag.
// Depends on msb_pkg.
module msb_ctrl
  import msb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output msb_cmd_t cmd
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid & in_ready;
  assign out_free   = ~out_valid_r | out_ready;
  assign cmd.load   = accept;
  assign cmd.commit = (state_r == S_EXEC) & out_free;
  assign out_valid  = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // wait here while the result register is still occupied
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_EXEC) && !in_ready)
    else $error("accepted request did not enter execute");

  a_commit_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit without result word");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.commit))
    else $error("load and commit in one cycle");

endmodule

/* rtl/msb_dp.sv */
`timescale 1ns / 1ps
// Datapath: stack tops, free-list head, link and value memories, result register.
// Depends on msb_pkg and msb_ram.
module msb_dp
  import msb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  msb_cmd_t                 cmd,
  input  logic                     in_req_type,
  input  logic [SID_W-1:0]         in_stack_id,
  input  logic signed [DATA_W-1:0] in_push_value,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [DATA_W-1:0] out_pop_value
);

  logic [LINK_W-1:0] tops_r [NUM_STACKS];
  logic [LINK_W-1:0] free_head_r;
  logic [NUM_SLOTS-1:0] link_vld_r;

  logic              req_type_r;
  logic [STK_IW-1:0] sid_r;
  logic [DATA_W-1:0] val_r;
  logic              refuse_r;
  logic [SLOT_W-1:0] slot_r;
  logic              lnk_vld_r;
  logic [STAT_W-1:0] status_r;
  logic [DATA_W-1:0] pop_value_r;

  logic [STK_IW-1:0] sid_idx;
  logic              sid_ok;
  logic [LINK_W-1:0] target;
  logic              refuse;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic [LINK_W-1:0] lnk_rdata;
  logic [DATA_W-1:0] val_rdata;
  logic [LINK_W-1:0] link_eff;
  logic              do_write;
  logic              do_push;
  logic              val_we;
  logic [LINK_W-1:0] link_wdata;

  // request decode at accept
  assign sid_idx = STK_IW'(in_stack_id);
  assign sid_ok  = 32'(in_stack_id) < NUM_STACKS;
  assign target  = (in_req_type == REQ_PUSH) ? free_head_r : tops_r[sid_idx];
  assign refuse  = ~sid_ok | link_is_null(target);
  assign rd_en   = cmd.load & ~refuse;
  assign rd_addr = target[SLOT_W-1:0];

  // never-written link entries are taken as their reset chain value slot+1
  assign link_eff = link_norm(lnk_vld_r ? lnk_rdata
                                        : LINK_W'(slot_r) + LINK_W'(1));

  assign do_write   = cmd.commit & ~refuse_r;
  assign do_push    = do_write & (req_type_r == REQ_PUSH);
  assign val_we     = do_push;
  assign link_wdata = (req_type_r == REQ_PUSH) ? tops_r[sid_r] : free_head_r;

  msb_ram #(.WIDTH(LINK_W), .DEPTH(NUM_SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (do_write),
    .waddr (slot_r),
    .wdata (link_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (lnk_rdata)
  );

  msb_ram #(.WIDTH(DATA_W), .DEPTH(NUM_SLOTS)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (slot_r),
    .wdata (val_r),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (val_rdata)
  );

  // list state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        tops_r[i] <= LINK_NULL;
      end
      free_head_r <= '0;
      link_vld_r  <= '0;
    end else if (do_write) begin
      link_vld_r[slot_r] <= 1'b1;
      if (req_type_r == REQ_PUSH) begin
        free_head_r   <= link_eff;
        tops_r[sid_r] <= LINK_W'(slot_r);
      end else begin
        tops_r[sid_r] <= link_eff;
        free_head_r   <= LINK_W'(slot_r);
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_r <= in_req_type;
      sid_r      <= sid_idx;
      val_r      <= in_push_value;
      refuse_r   <= refuse;
      slot_r     <= rd_addr;
      lnk_vld_r  <= link_vld_r[rd_addr];
    end
    if (cmd.commit) begin
      if (refuse_r) begin
        status_r <= (req_type_r == REQ_PUSH) ? ST_FULL : ST_EMPTY;
      end else begin
        status_r <= ST_DONE;
      end
      pop_value_r <= (do_write && req_type_r == REQ_POP) ? val_rdata : '0;
    end
  end

  assign out_status    = status_r;
  assign out_pop_value = pop_value_r;

  a_free_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(free_head_r) <= NUM_SLOTS)
    else $error("free head outside slot range");

  a_push_links_top: assert property (@(posedge clk) disable iff (!rst_n)
    do_push |=> tops_r[$past(sid_r)] == LINK_W'($past(slot_r)))
    else $error("push did not move stack top to new slot");

endmodule

/* rtl/multi_stack_shared_buffer_top.sv */
`timescale 1ns / 1ps
// Several LIFO stacks sharing one 64-slot store through a linked free list.
// Input channel (in_valid/in_ready): one request word per handshake, either a
// push of in_push_value onto stack in_stack_id or a pop from it.
// Result channel (out_valid/out_ready): exactly one word per request, with
// out_status (done, store full, stack empty) and out_pop_value (popped value
// on a successful pop, zero otherwise).
// Each request passes through a load step and a commit step: load reads the
// link and value memories at the free head or stack top; commit writes the
// link memory (and the value memory on a push), updates the pointers and
// loads the output register, raising out_valid. Commit waits while the
// output register is occupied; no new request is taken until it is done.
// A finished word waits in the output register; the block takes the next
// request while it waits, but holds that request's commit until the word is
// taken, so out_ready low stalls the input after one more request.
// Reset: all stacks empty, the free list holds every slot in order; no
// clearing pass is needed, the block is ready as soon as reset is released.
// Depends on msb_pkg, msb_ctrl, msb_dp and msb_ram.
module multi_stack_shared_buffer_top
  import msb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_req_type,
  input  logic [SID_W-1:0]         in_stack_id,
  input  logic signed [DATA_W-1:0] in_push_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [DATA_W-1:0] out_pop_value
);

  msb_cmd_t cmd;

  msb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  msb_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_req_type   (in_req_type),
    .in_stack_id   (in_stack_id),
    .in_push_value (in_push_value),
    .out_status    (out_status),
    .out_pop_value (out_pop_value)
  );

endmodule
